// ----- rtl/tcpq_pkg.sv -----
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared types and codes for the two-class priority ticket queue: request and
// result words, opcodes, status codes and the ring control/status groups.
// ----------------------------------------------------------------------------
package tcpq_pkg;

    // ticket width is fixed by the service numbering
    localparam int unsigned TICKET_W = 11;
    localparam int unsigned OPCODE_W = 2;
    localparam int unsigned STATUS_W = 3;

    // request opcodes
    typedef enum logic [OPCODE_W-1:0] {
        OP_ENQ_NORMAL = 2'd0,
        OP_ENQ_PREF   = 2'd1,
        OP_CALL       = 2'd2
    } t_opcode;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_CALL_NORMAL = 3'd0,
        ST_CALL_PREF   = 3'd1,
        ST_NONE        = 3'd2,
        ST_ENQUEUED    = 3'd3,
        ST_REFUSED     = 3'd4
    } t_status;

    // request word
    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [TICKET_W-1:0] ticket_value;
    } t_in_item;

    // result word
    typedef struct packed {
        t_status             status;
        logic [TICKET_W-1:0] called_ticket;
    } t_out_item;

    // commands into one ring
    typedef struct packed {
        logic push;
        logic pop;
    } t_ring_ctl;

    // occupancy flags out of one ring
    typedef struct packed {
        logic full;
        logic empty;
    } t_ring_sts;

endpackage

// ----- rtl/tcpq_ram.sv -----
// ----------------------------------------------------------------------------
// tcpq_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that updates only when a read is enabled.
// ----------------------------------------------------------------------------
module tcpq_ram #(
    parameter int unsigned WIDTH = 11,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/tcpq_ring.sv -----
// ----------------------------------------------------------------------------
// tcpq_ring
// One bounded FIFO of tickets: head, tail and count registers around a RAM.
// A pop launches the read of the head entry; its data shows in the cycle
// after the pop and holds until the next pop.
// ----------------------------------------------------------------------------
module tcpq_ring #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tcpq_pkg::t_ring_ctl            i_ctl,
    input  logic [tcpq_pkg::TICKET_W-1:0]  i_push_data,
    output tcpq_pkg::t_ring_sts            o_sts,
    output logic [tcpq_pkg::TICKET_W-1:0]  o_rd_data
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;

    // pointer wrap, depth need not be a power of two
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_ctl.push) begin
            n_tail  = (r_tail == AW'(DEPTH - 1)) ? '0 : r_tail + AW'(1);
            n_count = r_count + CW'(1);
        end
        if (i_ctl.pop) begin
            n_head  = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    assign o_sts.full  = (r_count == CW'(DEPTH));
    assign o_sts.empty = (r_count == '0);

    // ticket storage
    tcpq_ram #(
        .WIDTH (tcpq_pkg::TICKET_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_ctl.push),
        .i_wr_addr (r_tail),
        .i_wr_data (i_push_data),
        .i_rd_en   (i_ctl.pop),
        .i_rd_addr (r_head),
        .o_rd_data (o_rd_data)
    );

    // the top level only pushes into a ring that has room and pops a ring
    // that holds something, and never both in one cycle
    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.push |-> !o_sts.full)
        else $error("push into full ring");

    a_no_underflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.pop |-> !o_sts.empty)
        else $error("pop from empty ring");

    a_one_op : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctl.push && i_ctl.pop))
        else $error("push and pop in the same cycle");

endmodule

// ----- rtl/two_class_priority_ticket_queue.sv -----
// ----------------------------------------------------------------------------
// two_class_priority_ticket_queue
// Strict-priority ticket dispatcher over a normal and a preferential FIFO.
// ----------------------------------------------------------------------------
// One request word is taken per clock cycle while the result side keeps up,
// and every request produces exactly one result word, in order. A request is
// decided in the cycle it is accepted (push, pop or refusal, chosen from the
// queue counts); its result then passes the registered read port of the ticket
// RAM and leaves through the output register.
// Calls serve the preferential head first and the normal head only when the
// preferential queue is empty; enqueues into a full queue and unused opcodes
// are refused. Each queue holds QUEUE_DEPTH tickets. The pipeline register in
// front of the output lets one more request in while a result waits.
// ----------------------------------------------------------------------------
module two_class_priority_ticket_queue #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tcpq_pkg::t_in_item  i_in_data,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tcpq_pkg::t_out_item o_out_data
);

    tcpq_pkg::t_ring_ctl            norm_ctl, pref_ctl;
    tcpq_pkg::t_ring_sts            norm_sts, pref_sts;
    logic [tcpq_pkg::TICKET_W-1:0]  norm_rd_data, pref_rd_data;

    logic                in_fire;
    logic                s1_adv;
    tcpq_pkg::t_status   n_status;
    logic                n_from_norm, n_from_pref;

    logic                r_s1_valid;
    tcpq_pkg::t_status   r_s1_status;
    logic                r_s1_from_norm, r_s1_from_pref;

    logic                r_out_valid;
    tcpq_pkg::t_out_item r_out, n_out;

    // handshake
    assign s1_adv     = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_fire    = i_in_valid && o_in_ready;

    // request decode and priority choice
    always_comb begin
        norm_ctl    = '0;
        pref_ctl    = '0;
        n_from_norm = 1'b0;
        n_from_pref = 1'b0;
        n_status    = tcpq_pkg::ST_REFUSED;
        unique case (i_in_data.opcode)
            tcpq_pkg::OP_ENQ_NORMAL: begin
                if (!norm_sts.full) begin
                    norm_ctl.push = in_fire;
                    n_status      = tcpq_pkg::ST_ENQUEUED;
                end
            end
            tcpq_pkg::OP_ENQ_PREF: begin
                if (!pref_sts.full) begin
                    pref_ctl.push = in_fire;
                    n_status      = tcpq_pkg::ST_ENQUEUED;
                end
            end
            tcpq_pkg::OP_CALL: begin
                if (!pref_sts.empty) begin
                    pref_ctl.pop = in_fire;
                    n_from_pref  = 1'b1;
                    n_status     = tcpq_pkg::ST_CALL_PREF;
                end else if (!norm_sts.empty) begin
                    norm_ctl.pop = in_fire;
                    n_from_norm  = 1'b1;
                    n_status     = tcpq_pkg::ST_CALL_NORMAL;
                end else begin
                    n_status     = tcpq_pkg::ST_NONE;
                end
            end
            default: begin
                n_status = tcpq_pkg::ST_REFUSED;
            end
        endcase
    end

    // queues
    tcpq_ring #(
        .DEPTH (QUEUE_DEPTH)
    ) u_norm_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (norm_ctl),
        .i_push_data (i_in_data.ticket_value),
        .o_sts       (norm_sts),
        .o_rd_data   (norm_rd_data)
    );

    tcpq_ring #(
        .DEPTH (QUEUE_DEPTH)
    ) u_pref_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (pref_ctl),
        .i_push_data (i_in_data.ticket_value),
        .o_sts       (pref_sts),
        .o_rd_data   (pref_rd_data)
    );

    // stage one: status and source wait for the ram read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_status    <= n_status;
            r_s1_from_norm <= n_from_norm;
            r_s1_from_pref <= n_from_pref;
        end
    end

    // pick the called ticket, zero when nothing was removed
    always_comb begin
        n_out.status = r_s1_status;
        if (r_s1_from_pref) begin
            n_out.called_ticket = pref_rd_data;
        end else if (r_s1_from_norm) begin
            n_out.called_ticket = norm_rd_data;
        end else begin
            n_out.called_ticket = '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a call with preferential tickets waiting is always served from there
    a_pref_first : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_data.opcode == tcpq_pkg::OP_CALL && !pref_sts.empty)
        |=> (r_s1_valid && r_s1_status == tcpq_pkg::ST_CALL_PREF))
        else $error("call skipped a waiting preferential ticket");

    // an enqueue into a full normal queue is refused
    a_full_refused : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_data.opcode == tcpq_pkg::OP_ENQ_NORMAL && norm_sts.full)
        |=> (r_s1_status == tcpq_pkg::ST_REFUSED))
        else $error("enqueue into full normal queue not refused");

    // only a call result carries a ticket
    a_zero_ticket : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != tcpq_pkg::ST_CALL_NORMAL
            && r_out.status != tcpq_pkg::ST_CALL_PREF)
        |-> (r_out.called_ticket == '0))
        else $error("non-call result carries a ticket");

    // a stalled stage-one entry is not lost or replaced
    a_s1_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv)
        |=> (r_s1_valid && $stable(r_s1_status) && $stable(r_s1_from_pref)))
        else $error("stage one entry lost under stall");

endmodule

// ----- sim/two_class_priority_ticket_queue_tb.sv -----
// ----------------------------------------------------------------------------
// two_class_priority_ticket_queue_tb
// Self-checking bench for the two-class priority ticket queue. Request words
// are driven with random gaps, and the result side stalls at random. Each
// accepted request runs through a local model of the two ticket rings, and
// the expected result word is queued for comparison. Every result word is
// compared field by field with the oldest expected one. The stimulus covers
// corner tickets, all opcodes, the unused opcode, full and empty rings, a long
// output hold-off, and long random phases of fill, drain and mixed traffic.
// ----------------------------------------------------------------------------
module two_class_priority_ticket_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [tcpq_pkg::TICKET_W-1:0] t_ticket;
    typedef logic [tcpq_pkg::OPCODE_W-1:0] t_op_bits;

    localparam int unsigned QUEUE_DEPTH  = 16;
    localparam int unsigned CLK_HALF     = 5;
    localparam int unsigned RESET_CYCLES = 4;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned RANDOM_WORDS = 2000;
    localparam int unsigned CALM_WORDS   = 250;
    localparam int unsigned HOLD_CYCLES  = 300;

    // opcode value that the block has no meaning for
    localparam t_op_bits OP_UNUSED  = 2'd3;
    localparam t_ticket  TICKET_TOP = '1;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    tcpq_pkg::t_in_item  i_in_data = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    tcpq_pkg::t_out_item o_out_data;

    // model of the two ticket rings and the results still owed
    t_ticket             normal_line[$];
    t_ticket             preferred_line[$];
    tcpq_pkg::t_out_item pending_results[$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    bit          hold_armed = 1'b0;
    bit          idling_on = 1'b1;

    two_class_priority_ticket_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // clock
    always #CLK_HALF i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // one line per mismatch
    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // strict-priority dispatch over the two rings, one result per request
    function automatic tcpq_pkg::t_out_item serve_request(input tcpq_pkg::t_in_item req);
        tcpq_pkg::t_out_item res;
        res.status        = tcpq_pkg::ST_REFUSED;
        res.called_ticket = '0;
        case (req.opcode)
            tcpq_pkg::OP_ENQ_NORMAL: begin
                if (normal_line.size() < QUEUE_DEPTH) begin
                    normal_line.push_back(req.ticket_value);
                    res.status = tcpq_pkg::ST_ENQUEUED;
                end
            end
            tcpq_pkg::OP_ENQ_PREF: begin
                if (preferred_line.size() < QUEUE_DEPTH) begin
                    preferred_line.push_back(req.ticket_value);
                    res.status = tcpq_pkg::ST_ENQUEUED;
                end
            end
            tcpq_pkg::OP_CALL: begin
                if (preferred_line.size() != 0) begin
                    res.called_ticket = preferred_line.pop_front();
                    res.status        = tcpq_pkg::ST_CALL_PREF;
                end else if (normal_line.size() != 0) begin
                    res.called_ticket = normal_line.pop_front();
                    res.status        = tcpq_pkg::ST_CALL_NORMAL;
                end else begin
                    res.status = tcpq_pkg::ST_NONE;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // send one request word and record what it should produce
    task automatic send_word(input t_op_bits op, input t_ticket ticket);
        tcpq_pkg::t_in_item req;
        int unsigned gap;
        req.opcode       = op;
        req.ticket_value = ticket;
        @(negedge i_clk);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = req;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(serve_request(req));
    endtask

    // result side: long hold-off, random stall bursts or ready
    initial begin
        int unsigned stall_left;
        int unsigned hold_left;
        bit          hold_done;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_armed && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready = 1'b0;
            end else if (idling_on && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(1, 7) - 1;
                i_out_ready = 1'b0;
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    // compare each result word with the oldest expected one
    always @(posedge i_clk) begin : result_check
        tcpq_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result status", o_out_data.status, -1);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.status !== want.status)
                    report_mismatch("status", o_out_data.status, want.status);
                if (o_out_data.called_ticket !== want.called_ticket)
                    report_mismatch("called_ticket", o_out_data.called_ticket,
                                    want.called_ticket);
            end
        end
    end

    // corner tickets, every opcode, empty calls and priority order
    task automatic test_directed_cases();
        send_word(tcpq_pkg::OP_CALL, '0);
        send_word(OP_UNUSED, TICKET_TOP);
        send_word(tcpq_pkg::OP_ENQ_NORMAL, '0);
        send_word(tcpq_pkg::OP_ENQ_NORMAL, TICKET_TOP);
        send_word(tcpq_pkg::OP_ENQ_NORMAL, 11'd1999);
        send_word(tcpq_pkg::OP_ENQ_PREF, 11'd2000);
        send_word(tcpq_pkg::OP_ENQ_PREF, 11'd1);
        send_word(OP_UNUSED, 11'h555);
        send_word(tcpq_pkg::OP_CALL, 11'h2AA);
        send_word(tcpq_pkg::OP_ENQ_PREF, 11'd1024);
        send_word(tcpq_pkg::OP_CALL, '0);
        send_word(tcpq_pkg::OP_CALL, '0);
        send_word(tcpq_pkg::OP_CALL, '0);
        send_word(tcpq_pkg::OP_CALL, '0);
        send_word(tcpq_pkg::OP_CALL, '0);
        send_word(tcpq_pkg::OP_CALL, '0);
        send_word(tcpq_pkg::OP_CALL, TICKET_TOP);
        send_word(OP_UNUSED, '0);
    endtask

    // fill both rings past capacity, then drain past empty
    task automatic test_full_queues();
        repeat (QUEUE_DEPTH + 1)
            send_word(tcpq_pkg::OP_ENQ_NORMAL, t_ticket'($urandom_range(0, 2047)));
        repeat (QUEUE_DEPTH + 1)
            send_word(tcpq_pkg::OP_ENQ_PREF, t_ticket'($urandom_range(0, 2047)));
        repeat (2 * QUEUE_DEPTH + 1)
            send_word(tcpq_pkg::OP_CALL, t_ticket'($urandom_range(0, 2047)));
    endtask

    // result side holds off while requests keep coming, so the input stalls
    task automatic test_output_hold();
        hold_armed = 1'b1;
        repeat (6) send_word(tcpq_pkg::OP_ENQ_PREF, t_ticket'($urandom_range(0, 2047)));
        repeat (6) send_word(tcpq_pkg::OP_CALL, t_ticket'($urandom_range(0, 2047)));
    endtask

    // random traffic in fill, drain and mixed stretches
    task automatic test_random_traffic(input int unsigned n_words);
        int unsigned mode;
        int unsigned pick;
        t_op_bits    op;
        mode = 0;
        for (int unsigned k = 0; k < n_words; k++) begin
            if (k % 40 == 0)
                mode = $urandom_range(0, 2);
            pick = $urandom_range(0, 99);
            if (pick < 3)
                op = OP_UNUSED;
            else if ((mode == 0 && pick < 80) || (mode == 1 && pick < 25)
                     || (mode == 2 && pick < 50))
                op = ($urandom_range(0, 1) == 0) ? tcpq_pkg::OP_ENQ_NORMAL
                                                 : tcpq_pkg::OP_ENQ_PREF;
            else
                op = tcpq_pkg::OP_CALL;
            send_word(op, t_ticket'($urandom_range(0, 2047)));
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_cases();
        test_full_queues();
        test_output_hold();
        test_random_traffic(RANDOM_WORDS - CALM_WORDS);

        // last stretch runs without gaps or stalls
        idling_on = 1'b0;
        test_random_traffic(CALM_WORDS);
        @(negedge i_clk);
        i_in_valid = 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
